>>> hw/rtl/hex_snowflake_automaton_step_core_macros.svh
// Assertion macros shared by the checker of the snowflake automaton core.
// Each macro takes a label, clock, active-low reset, antecedent, consequent and message.
`ifndef HEX_SNOWFLAKE_AUTOMATON_STEP_CORE_MACROS_SVH
`define HEX_SNOWFLAKE_AUTOMATON_STEP_CORE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define HSA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define HSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/hsa_pkg.sv
// Package of the snowflake automaton core: grid sizes, command types and
// the neighbor folding function. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package hsa_pkg;

  localparam int GRID_LEVELS   = 256;
  localparam int FRACTION_BITS = 28;
  localparam int ROW_SLOTS     = GRID_LEVELS / 2 + 1;
  localparam int CELL_COUNT    = GRID_LEVELS * ROW_SLOTS;
  localparam int ADDR_W        = $clog2(CELL_COUNT);
  localparam int LEVEL_W       = $clog2(GRID_LEVELS);
  localparam int COL_W         = $clog2(ROW_SLOTS);
  localparam int CW            = LEVEL_W + 2;
  localparam int DATA_W        = 32;
  localparam int IN_DATA_W     = 16;
  localparam int MODE_W        = 2;
  localparam int OUT_USER_W    = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int SUM_W         = DATA_W + 3;
  localparam int KEEP_W        = FRACTION_BITS + 2;
  localparam int DIV_W         = 40;

  typedef logic [DATA_W-1:0] fx_t;

  localparam fx_t ONE_FX      = fx_t'(64'd1 << FRACTION_BITS);
  localparam fx_t TWO_ONE_FX  = fx_t'(64'd1 << (FRACTION_BITS + 1));
  localparam fx_t RESET_ALPHA = 32'd134754601;
  localparam fx_t RESET_BETA  = 32'd107374182;
  localparam fx_t RESET_GAMMA = 32'd26844;

  typedef enum logic [MODE_W-1:0] {
    OP_INIT    = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_READ    = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA = 2'd0,
    CFG_BETA  = 2'd1,
    CFG_GAMMA = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    op_e               op;
    logic              oor;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic              beyond;
    logic [ADDR_W-1:0] addr;
  } fold_t;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [LEVEL_W-1:0] row,
                                                  logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(ROW_SLOTS) + ADDR_W'(col);
  endfunction

  function automatic logic ge_one(fx_t v);
    return v >= ONE_FX;
  endfunction

  function automatic fold_t fold_coord(coord_t i, coord_t j);
    fold_t  r;
    coord_t ii;
    coord_t jj;
    coord_t rs;
    ii = i;
    jj = j;
    r.beyond = (ii >= coord_t'(GRID_LEVELS));
    if (ii < coord_t'(0)) begin
      ii = coord_t'(1);
      jj = coord_t'(0);
    end
    if (ii <= coord_t'(1)) begin
      jj = coord_t'(0);
    end
    if (jj < coord_t'(0)) begin
      jj = -jj;
    end
    rs = (ii >>> 1) + coord_t'(1);
    if (jj >= rs) begin
      jj = ii[0] ? (rs <<< 1) - coord_t'(1) - jj : (rs <<< 1) - coord_t'(2) - jj;
    end
    if (jj < coord_t'(0)) begin
      jj = -jj;
    end
    if (jj >= rs) begin
      jj = rs - coord_t'(1);
    end
    r.addr = r.beyond ? '0 : cell_addr(ii[LEVEL_W-1:0], jj[COL_W-1:0]);
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hex_snowflake_automaton_step_core.sv
// Top level of the snowflake automaton core: configuration registers, the
// command front end and the sequencing back end. Depends on hsa_pkg,
// hsa_front and hsa_back.
//
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata level, position; tuser mode
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata cell_value; tuser frozen, out_of_range
// cfg       in         cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// Initialize makes one bank write per cycle over every slot. Advance makes a
// receptive pass and then an update pass over every cell, fetching each cell's
// neighbors and the cell itself through the single read port of each bank.
// A two-beat command queue lets input beats be taken while a result waits on
// m_axis. Reset clears the bank select and control only.
`timescale 1ns / 1ps
`default_nettype none

module hex_snowflake_automaton_step_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [hsa_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // level, position
  input  wire logic [hsa_pkg::MODE_W-1:0]        s_axis_tuser,  // mode
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic      [hsa_pkg::DATA_W-1:0]        m_axis_tdata,  // cell_value
  output logic      [hsa_pkg::OUT_USER_W-1:0]    m_axis_tuser,  // frozen, out_of_range
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [hsa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [hsa_pkg::DATA_W-1:0]        cfg_data_i
);

  import hsa_pkg::*;

  fx_t  alpha_q, beta_q, gamma_q;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= RESET_ALPHA;
      beta_q  <= RESET_BETA;
      gamma_q <= RESET_GAMMA;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ALPHA: alpha_q <= cfg_data_i;
        CFG_BETA:  beta_q  <= cfg_data_i;
        CFG_GAMMA: gamma_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hsa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_mode_i   (s_axis_tuser),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  hsa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .alpha_i     (alpha_q),
    .beta_i      (beta_q),
    .gamma_i     (gamma_q),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_o  (m_axis_tdata),
    .res_user_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire

>>> hw/rtl/hsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module hsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> hw/rtl/hsa_front.sv
// Front end: accepts input beats, decodes them into commands and queues
// them in a two-entry buffer. Depends on hsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsa_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [hsa_pkg::IN_DATA_W-1:0]   in_data_i,
  input  wire logic [hsa_pkg::MODE_W-1:0]      in_mode_i,
  output logic                                 cmd_valid_o,
  output hsa_pkg::cmd_t                        cmd_o,
  input  wire logic                            cmd_pop_i
);

  import hsa_pkg::*;

  cmd_t                 slot_q [2];
  logic                 wr_ptr_q, wr_ptr_d;
  logic                 rd_ptr_q, rd_ptr_d;
  logic [1:0]           count_q, count_d;
  cmd_t                 cmd_new;
  logic [LEVEL_W-1:0]   level;
  logic [COL_W:0]       position;
  logic                 push;

  assign level    = in_data_i[LEVEL_W-1:0];
  assign position = (COL_W + 1)'(in_data_i[15:8]);

  always_comb begin
    cmd_new.op   = op_e'(in_mode_i);
    cmd_new.oor  = position >= (COL_W + 1)'((level >> 1) + LEVEL_W'(1));
    cmd_new.addr = cell_addr(level, position[COL_W-1:0]);
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ cmd_pop_i;
    count_d  = count_q + 2'(push) - 2'(cmd_pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/hsa_back.sv
// Back end: sequencer that runs initialize, advance, read and nop commands over
// the two cell banks and the flag store. Depends on hsa_pkg and hsa_ram.
`timescale 1ns / 1ps
`default_nettype none

module hsa_back (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cmd_valid_i,
  input  hsa_pkg::cmd_t                         cmd_i,
  output logic                                  cmd_pop_o,
  input  wire logic [hsa_pkg::DATA_W-1:0]       alpha_i,
  input  wire logic [hsa_pkg::DATA_W-1:0]       beta_i,
  input  wire logic [hsa_pkg::DATA_W-1:0]       gamma_i,
  output logic                                  res_valid_o,
  input  wire logic                             res_ready_i,
  output logic      [hsa_pkg::DATA_W-1:0]       res_data_o,
  output logic      [hsa_pkg::OUT_USER_W-1:0]   res_user_o
);

  import hsa_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_INIT   = 12'b0000_0000_0010,
    S_RDWAIT = 12'b0000_0000_0100,
    S_SCAN   = 12'b0000_0000_1000,
    S_LAST   = 12'b0000_0001_0000,
    S_MUL1   = 12'b0000_0010_0000,
    S_MUL2   = 12'b0000_0100_0000,
    S_SUM    = 12'b0000_1000_0000,
    S_DIV    = 12'b0001_0000_0000,
    S_WRITE  = 12'b0010_0000_0000,
    S_NEXT   = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } state_e;

  localparam logic [2:0] OWN_STEP = 3'd6;
  localparam int BASE_W = DATA_W + 1;
  localparam int TOT_W  = DIV_W + 1;
  localparam logic [LEVEL_W-1:0] LAST_ROW = LEVEL_W'(GRID_LEVELS - 1);

  state_e               state_q, state_d;
  logic                 active_q, active_d;
  logic                 pass_q, pass_d;
  logic [LEVEL_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]     col_q, col_d;
  logic [2:0]           step_q, step_d;
  logic                 issue_q, issue_d;
  logic                 beyond_q, beyond_d;
  logic [2:0]           dstep_q, dstep_d;
  logic [ADDR_W-1:0]    init_addr_q, init_addr_d;
  logic                 rcpt_q, rcpt_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  fx_t                  own_q, own_d;
  logic                 own_flag_q, own_flag_d;
  logic [63:0]          plo_q, plo_d;
  logic [SUM_W-1:0]     phi_q, phi_d;
  logic [BASE_W-1:0]    base_q, base_d;
  logic [DIV_W-1:0]     dvd_q, dvd_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [1:0]           rem_q, rem_d;
  logic [2:0]           dcnt_q, dcnt_d;
  fx_t                  pend_val_q, pend_val_d;
  logic                 pend_frz_q, pend_frz_d;
  logic                 pend_oor_q, pend_oor_d;
  logic                 res_valid_q, res_valid_d;
  fx_t                  res_val_q, res_val_d;
  logic [OUT_USER_W-1:0] res_user_q, res_user_d;

  logic [ADDR_W-1:0]    raddr;
  logic [ADDR_W-1:0]    waddr;
  logic [ADDR_W-1:0]    cur_addr;
  fx_t                  wdata;
  logic                 we_a, we_b, we_f;
  fx_t                  rd_a, rd_b, rd_src;
  logic                 rd_f;
  coord_t               nb_i, nb_j;
  fold_t                nb_fold;
  logic [KEEP_W-1:0]    keep;
  logic [DATA_W+KEEP_W-1:0] bprod;
  logic [66:0]          wide_sum;
  logic [TOT_W-1:0]     total;
  logic [DIV_W-1:0]     div_dvd_n, div_quo_n;
  logic [1:0]           div_rem_n;

  assign cur_addr = cell_addr(row_q, col_q);
  assign rd_src   = active_q ? rd_b : rd_a;
  assign keep     = (alpha_i < TWO_ONE_FX) ? KEEP_W'(TWO_ONE_FX - alpha_i) : '0;
  assign bprod    = own_q * keep;
  assign wide_sum = {phi_q, 32'b0} + 67'(plo_q);
  assign total    = TOT_W'(base_q) + TOT_W'(quo_q);

  assign res_valid_o = res_valid_q;
  assign res_data_o  = res_val_q;
  assign res_user_o  = res_user_q;

  // Neighbor list per cell; rows 0 and the first column repeat entries so that
  // every cell takes six neighbor fetches and one fetch of itself.
  always_comb begin
    coord_t ci;
    coord_t cj;
    ci = coord_t'(row_q);
    cj = coord_t'(col_q);
    nb_i = ci;
    nb_j = cj;
    if (step_q == OWN_STEP) begin
      nb_i = ci;
      nb_j = cj;
    end else if (row_q == '0) begin
      nb_i = coord_t'(1);
      nb_j = coord_t'(0);
    end else if (col_q == '0) begin
      case (step_q)
        3'd0, 3'd1: begin nb_i = ci;               nb_j = coord_t'(1); end
        3'd2, 3'd3: begin nb_i = ci + coord_t'(1); nb_j = coord_t'(1); end
        3'd4:       begin nb_i = ci + coord_t'(1); nb_j = coord_t'(0); end
        default:    begin nb_i = ci - coord_t'(1); nb_j = coord_t'(0); end
      endcase
    end else begin
      case (step_q)
        3'd0:    begin nb_i = ci;               nb_j = cj - coord_t'(1); end
        3'd1:    begin nb_i = ci;               nb_j = cj + coord_t'(1); end
        3'd2:    begin nb_i = ci + coord_t'(1); nb_j = cj;               end
        3'd3:    begin nb_i = ci + coord_t'(1); nb_j = cj + coord_t'(1); end
        3'd4:    begin nb_i = ci - coord_t'(1); nb_j = cj;               end
        default: begin nb_i = ci - coord_t'(1); nb_j = cj - coord_t'(1); end
      endcase
    end
    nb_fold = fold_coord(nb_i, nb_j);
  end

  // Eight quotient bits per cycle of the division by three.
  always_comb begin
    logic [DIV_W-1:0] dv;
    logic [DIV_W-1:0] qv;
    logic [1:0]       rv;
    logic [2:0]       r3;
    dv = dvd_q;
    qv = quo_q;
    rv = rem_q;
    for (int b = 0; b < 8; b++) begin
      r3 = {rv, dv[DIV_W-1]};
      dv = {dv[DIV_W-2:0], 1'b0};
      if (r3 >= 3'd3) begin
        rv = 2'(r3 - 3'd3);
        qv = {qv[DIV_W-2:0], 1'b1};
      end else begin
        rv = r3[1:0];
        qv = {qv[DIV_W-2:0], 1'b0};
      end
    end
    div_dvd_n = dv;
    div_quo_n = qv;
    div_rem_n = rv;
  end

  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    pass_d      = pass_q;
    row_d       = row_q;
    col_d       = col_q;
    step_d      = step_q;
    issue_d     = 1'b0;
    beyond_d    = beyond_q;
    dstep_d     = dstep_q;
    init_addr_d = init_addr_q;
    rcpt_d      = rcpt_q;
    sum_d       = sum_q;
    own_d       = own_q;
    own_flag_d  = own_flag_q;
    plo_d       = plo_q;
    phi_d       = phi_q;
    base_d      = base_q;
    dvd_d       = dvd_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    dcnt_d      = dcnt_q;
    pend_val_d  = pend_val_q;
    pend_frz_d  = pend_frz_q;
    pend_oor_d  = pend_oor_q;
    res_valid_d = res_valid_q && !res_ready_i;
    res_val_d   = res_val_q;
    res_user_d  = res_user_q;
    cmd_pop_o   = 1'b0;
    raddr       = '0;
    waddr       = cur_addr;
    wdata       = beta_i;
    we_a        = 1'b0;
    we_b        = 1'b0;
    we_f        = 1'b0;

    if (state_q == S_SCAN && step_q == '0) begin
      rcpt_d = 1'b0;
      sum_d  = '0;
    end

    if (issue_q) begin
      if (dstep_q == OWN_STEP) begin
        own_d      = rd_src;
        own_flag_d = rd_f;
        rcpt_d     = rcpt_d || ge_one(rd_src);
      end else if (!pass_q) begin
        rcpt_d = rcpt_d || ge_one(beyond_q ? beta_i : rd_src);
      end else begin
        sum_d = sum_d + SUM_W'(beyond_q ? beta_i : (rd_f ? '0 : rd_src));
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o  = 1'b1;
          pend_val_d = '0;
          pend_frz_d = 1'b0;
          pend_oor_d = 1'b0;
          raddr      = cmd_i.addr;
          case (cmd_i.op)
            OP_INIT: begin
              init_addr_d = '0;
              state_d     = S_INIT;
            end
            OP_ADVANCE: begin
              pass_d  = 1'b0;
              row_d   = '0;
              col_d   = '0;
              step_d  = '0;
              state_d = S_SCAN;
            end
            OP_READ: begin
              if (cmd_i.oor) begin
                pend_oor_d = 1'b1;
                state_d    = S_DONE;
              end else begin
                state_d = S_RDWAIT;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_INIT: begin
        waddr = init_addr_q;
        wdata = (init_addr_q == '0) ? ONE_FX : beta_i;
        we_a  = !active_q;
        we_b  = active_q;
        if (init_addr_q == ADDR_W'(CELL_COUNT - 1)) begin
          state_d = S_DONE;
        end else begin
          init_addr_d = init_addr_q + ADDR_W'(1);
        end
      end
      S_RDWAIT: begin
        pend_val_d = rd_src;
        pend_frz_d = ge_one(rd_src);
        state_d    = S_DONE;
      end
      S_SCAN: begin
        raddr    = nb_fold.addr;
        issue_d  = 1'b1;
        beyond_d = nb_fold.beyond;
        dstep_d  = step_q;
        if (step_q == OWN_STEP) begin
          step_d  = '0;
          state_d = S_LAST;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      S_LAST: begin
        state_d = pass_q ? S_MUL1 : S_NEXT;
      end
      S_MUL1: begin
        plo_d   = alpha_i * sum_q[DATA_W-1:0];
        state_d = S_MUL2;
      end
      S_MUL2: begin
        phi_d   = SUM_W'(alpha_i) * SUM_W'(sum_q[SUM_W-1:DATA_W]);
        base_d  = own_flag_q ? BASE_W'(own_q) + BASE_W'(gamma_i)
                             : BASE_W'(bprod >> (FRACTION_BITS + 1));
        state_d = S_SUM;
      end
      S_SUM: begin
        dvd_d   = DIV_W'(wide_sum >> (FRACTION_BITS + 2));
        quo_d   = '0;
        rem_d   = '0;
        dcnt_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        dvd_d  = div_dvd_n;
        quo_d  = div_quo_n;
        rem_d  = div_rem_n;
        dcnt_d = dcnt_q + 3'd1;
        if (dcnt_q == 3'(DIV_W / 8 - 1)) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        wdata   = (total > TOT_W'({DATA_W{1'b1}})) ? {DATA_W{1'b1}} : total[DATA_W-1:0];
        we_a    = active_q;
        we_b    = !active_q;
        state_d = S_NEXT;
      end
      S_NEXT: begin
        we_f    = !pass_q;
        state_d = S_SCAN;
        if (col_q == COL_W'(row_q >> 1)) begin
          col_d = '0;
          if (row_q == LAST_ROW) begin
            row_d = '0;
            if (!pass_q) begin
              pass_d = 1'b1;
            end else begin
              active_d = !active_q;
              state_d  = S_DONE;
            end
          end else begin
            row_d = row_q + LEVEL_W'(1);
          end
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
      S_DONE: begin
        if (!res_valid_q || res_ready_i) begin
          res_valid_d = 1'b1;
          res_val_d   = pend_val_q;
          res_user_d  = {pend_oor_q, pend_frz_q};
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  hsa_ram #(.WIDTH(DATA_W), .DEPTH(CELL_COUNT)) u_bank_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_a)
  );

  hsa_ram #(.WIDTH(DATA_W), .DEPTH(CELL_COUNT)) u_bank_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_b)
  );

  hsa_ram #(.WIDTH(1), .DEPTH(CELL_COUNT)) u_flags (
    .clk_i   (clk_i),
    .we_i    (we_f),
    .waddr_i (cur_addr),
    .wdata_i (rcpt_q),
    .raddr_i (raddr),
    .rdata_o (rd_f)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= 1'b0;
      pass_q      <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      step_q      <= '0;
      issue_q     <= 1'b0;
      beyond_q    <= 1'b0;
      dstep_q     <= '0;
      init_addr_q <= '0;
      rcpt_q      <= 1'b0;
      sum_q       <= '0;
      own_q       <= '0;
      own_flag_q  <= 1'b0;
      plo_q       <= '0;
      phi_q       <= '0;
      base_q      <= '0;
      dvd_q       <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      dcnt_q      <= '0;
      pend_val_q  <= '0;
      pend_frz_q  <= 1'b0;
      pend_oor_q  <= 1'b0;
      res_valid_q <= 1'b0;
      res_val_q   <= '0;
      res_user_q  <= '0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      pass_q      <= pass_d;
      row_q       <= row_d;
      col_q       <= col_d;
      step_q      <= step_d;
      issue_q     <= issue_d;
      beyond_q    <= beyond_d;
      dstep_q     <= dstep_d;
      init_addr_q <= init_addr_d;
      rcpt_q      <= rcpt_d;
      sum_q       <= sum_d;
      own_q       <= own_d;
      own_flag_q  <= own_flag_d;
      plo_q       <= plo_d;
      phi_q       <= phi_d;
      base_q      <= base_d;
      dvd_q       <= dvd_d;
      quo_q       <= quo_d;
      rem_q       <= rem_d;
      dcnt_q      <= dcnt_d;
      pend_val_q  <= pend_val_d;
      pend_frz_q  <= pend_frz_d;
      pend_oor_q  <= pend_oor_d;
      res_valid_q <= res_valid_d;
      res_val_q   <= res_val_d;
      res_user_q  <= res_user_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/hsa_checker.sv
// Port-level checker of the snowflake automaton core and its bind.
// Depends on hsa_pkg and hex_snowflake_automaton_step_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "hex_snowflake_automaton_step_core_macros.svh"

module hsa_assert (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  input  wire logic                              s_axis_tready,
  input  wire logic [hsa_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  wire logic [hsa_pkg::MODE_W-1:0]        s_axis_tuser,
  input  wire logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  input  wire logic [hsa_pkg::DATA_W-1:0]        m_axis_tdata,
  input  wire logic [hsa_pkg::OUT_USER_W-1:0]    m_axis_tuser,
  input  wire logic                              cfg_valid_i,
  input  wire logic                              cfg_ready_o,
  input  wire logic [hsa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [hsa_pkg::DATA_W-1:0]        cfg_data_i
);

  import hsa_pkg::*;

  `HSA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
                   "Stalled result beat changed.")
  `HSA_ASSERT_SAME(a_oor_clean, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1],
                   m_axis_tdata == '0 && !m_axis_tuser[0],
                   "Out-of-range beat carries a value.")
  `HSA_ASSERT_SAME(a_frozen_match, clk_i, rst_ni, m_axis_tvalid,
                   m_axis_tuser[0] == (m_axis_tdata >= ONE_FX),
                   "Frozen flag disagrees with the cell value.")

endmodule

bind hex_snowflake_automaton_step_core hsa_assert u_hsa_assert (.*);

`default_nettype wire
